### rtl/bplq_pkg.sv
// Package: widths, event codes, register indexes and lane result type for the button qualifier.
`default_nettype none
package bplq_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int LEVELS_W    = 6;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int COUNT_W     = 17;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int SLOTS       = 2 * NUM_BUTTONS;
    localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int S_TDATA_W   = ((LEVELS_W + TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((IDX_W + 1 + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] EV_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] EV_PRESS    = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONG     = 2'd2;
    localparam logic [KIND_W-1:0] EV_LONG_REL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_REARM_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_SCANS = 1'b1;

    localparam logic [CFG_W-1:0] REARM_TIME_RST = 16'd200;
    localparam logic [CFG_W-1:0] LONG_SCANS_RST = 16'd100;

    typedef struct packed {
        logic press;
        logic sec;
        logic sec_long;
        logic rearm;
    } lane_ev_t;

endpackage
`default_nettype wire

### rtl/bplq_lane.sv
// One button lane: arm state, press time, low-scan count and long-press tracking.
`default_nettype none
module bplq_lane
    import bplq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              scan_accept,
    input  wire logic              level,
    input  wire logic [TIME_W-1:0] time_ms,
    input  wire logic [CFG_W-1:0]  rearm_time_ms,
    input  wire logic [CFG_W-1:0]  long_press_scans,
    output lane_ev_t               ev
);

    logic               armed_reg, armed_next;
    logic               long_active_reg, long_active_next;
    logic [TIME_W-1:0]  press_time_reg, press_time_next;
    logic [COUNT_W-1:0] low_count_reg, low_count_next;
    logic [TIME_W-1:0]  elapsed;
    logic [COUNT_W-1:0] count_inc;
    logic               long_hit;

    always_comb begin
        elapsed   = time_ms - press_time_reg;
        count_inc = low_count_reg + COUNT_W'(1);
        long_hit  = !level && !long_active_reg &&
                    (count_inc > COUNT_W'(long_press_scans));

        ev.rearm    = !armed_reg && level &&
                      (elapsed > TIME_W'(rearm_time_ms));
        ev.press    = armed_reg && !level;
        ev.sec      = long_hit || (level && long_active_reg);
        ev.sec_long = long_hit;

        armed_next      = ev.press ? 1'b0 : (armed_reg | ev.rearm);
        press_time_next = ev.press ? time_ms : press_time_reg;
        if (level) begin
            low_count_next   = '0;
            long_active_next = 1'b0;
        end else if (long_active_reg) begin
            low_count_next   = low_count_reg;
            long_active_next = 1'b1;
        end else begin
            low_count_next   = long_hit ? '0 : count_inc;
            long_active_next = long_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg       <= 1'b1;
            long_active_reg <= 1'b0;
            press_time_reg  <= '0;
            low_count_reg   <= '0;
        end else if (scan_accept) begin
            armed_reg       <= armed_next;
            long_active_reg <= long_active_next;
            press_time_reg  <= press_time_next;
            low_count_reg   <= low_count_next;
        end
    end

endmodule
`default_nettype wire

### rtl/bplq_merge.sv
// Merge stage: collects scan events, tracks indicator, one beat per cycle unless stalled.
`default_nettype none
module bplq_merge
    import bplq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              scan_accept,
    output logic                   in_ready,
    input  wire lane_ev_t          lane_ev [NUM_BUTTONS],
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // button_index, indicator
    output logic [KIND_W-1:0]      m_tuser,   // event_kind
    output logic                   m_tlast
);

    logic [SLOTS-1:0]       mask_reg, mask_next;
    logic [NUM_BUTTONS-1:0] kind2_reg, kind2_next;
    logic                   none_reg, none_next;
    logic                   ind_reg, ind_next;
    logic                   m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]      m_kind_reg, m_kind_next;
    logic [IDX_W-1:0]       m_idx_reg, m_idx_next;
    logic                   m_ind_reg, m_ind_next;
    logic                   m_last_reg, m_last_next;

    logic [SLOTS-1:0]       new_mask;
    logic [NUM_BUTTONS-1:0] new_kind2;
    logic                   any_press, any_rearm;
    logic [SLOTS-1:0]       pick_onehot, rest;
    logic [BTN_W-1:0]       pick_btn;
    logic                   pick_sec, pick_long;
    logic                   batch_valid, batch_last, out_load, take;

    always_comb begin
        any_press = 1'b0;
        any_rearm = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            new_mask[2*i]   = lane_ev[i].press;
            new_mask[2*i+1] = lane_ev[i].sec;
            new_kind2[i]    = lane_ev[i].sec_long;
            any_press       = any_press | lane_ev[i].press;
            any_rearm       = any_rearm | lane_ev[i].rearm;
        end

        pick_onehot = mask_reg & (~mask_reg + SLOTS'(1));
        rest        = mask_reg & ~pick_onehot;
        pick_btn    = '0;
        pick_sec    = 1'b0;
        pick_long   = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (pick_onehot[j]) begin
                pick_btn  = BTN_W'(j / 2);
                pick_sec  = (j % 2) == 1;
                pick_long = kind2_reg[j / 2];
            end
        end

        batch_valid = none_reg | (|mask_reg);
        batch_last  = none_reg | (rest == '0);
        out_load    = !m_valid_reg | m_tready;
        take        = out_load & batch_valid;
        in_ready    = !batch_valid | (take & batch_last);

        mask_next  = mask_reg;
        kind2_next = kind2_reg;
        none_next  = none_reg;
        ind_next   = ind_reg;
        if (take) begin
            mask_next = rest;
            none_next = 1'b0;
        end
        if (scan_accept) begin
            mask_next  = new_mask;
            kind2_next = new_kind2;
            none_next  = (new_mask == '0);
            if (any_press) begin
                ind_next = 1'b1;
            end else if (any_rearm) begin
                ind_next = 1'b0;
            end
        end

        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_idx_next   = m_idx_reg;
        m_ind_next   = m_ind_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next = batch_valid;
        end
        if (take) begin
            m_ind_next  = ind_reg;
            m_last_next = batch_last;
            if (none_reg) begin
                m_kind_next = EV_NONE;
                m_idx_next  = '0;
            end else begin
                m_idx_next = IDX_W'(pick_btn);
                if (!pick_sec) begin
                    m_kind_next = EV_PRESS;
                end else if (pick_long) begin
                    m_kind_next = EV_LONG;
                end else begin
                    m_kind_next = EV_LONG_REL;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            none_reg    <= 1'b0;
            ind_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            none_reg    <= none_next;
            ind_reg     <= ind_next;
            m_valid_reg <= m_valid_next;
        end
        kind2_reg  <= kind2_next;
        m_kind_reg <= m_kind_next;
        m_idx_reg  <= m_idx_next;
        m_ind_reg  <= m_ind_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_ind_reg, m_idx_reg});
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    a_none_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_NONE) |-> (m_tlast && m_idx_reg == '0))
        else $error("none beat not alone or carries an index");

    a_none_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(none_reg && (|mask_reg)))
        else $error("none marker held alongside pending events");

    a_scan_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_accept |=> (none_reg || (|mask_reg)))
        else $error("accepted scan left no pending beat");

endmodule
`default_nettype wire

### rtl/button_press_long_press_qualifier.sv
// Top level: configuration registers, button lanes and the merge stage.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: levels, time_ms
//  m_      | out       | m_tvalid/m_tready  | m_tdata, m_tuser, m_tlast
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// All lanes evaluate an accepted scan together.
// A scan's beats go out in turn; scans of one beat flow at one per cycle unless the output stalls.
// The output register drains pending events one beat per cycle unless stalled, which sets the rate.
// Reset is synchronous; the block is ready as soon as reset is released, with no clearing pass.
// A stalled output holds its beat; the next scan is taken as soon as the pending set empties.
`default_nettype none
module button_press_long_press_qualifier
    import bplq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // levels[5:0], time_ms[37:6]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // button_index[2:0], indicator[3]
    output logic [KIND_W-1:0]          m_tuser,   // event_kind[1:0]
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    logic [CFG_W-1:0]       rearm_time_reg, rearm_time_next;
    logic [CFG_W-1:0]       long_scans_reg, long_scans_next;
    logic [LEVELS_W-1:0]    s_levels;
    logic [TIME_W-1:0]      s_time_ms;
    logic [NUM_BUTTONS-1:0] lane_level;
    lane_ev_t               lane_ev [NUM_BUTTONS];
    logic                   scan_accept;

    assign cfg_ready   = 1'b1;
    assign s_levels    = s_tdata[LEVELS_W-1:0];
    assign s_time_ms   = s_tdata[LEVELS_W+TIME_W-1:LEVELS_W];
    assign scan_accept = s_tvalid & s_tready;

    always_comb begin
        rearm_time_next = rearm_time_reg;
        long_scans_next = long_scans_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_REARM_TIME: rearm_time_next = cfg_data;
                REG_LONG_SCANS: long_scans_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rearm_time_reg <= REARM_TIME_RST;
            long_scans_reg <= LONG_SCANS_RST;
        end else begin
            rearm_time_reg <= rearm_time_next;
            long_scans_reg <= long_scans_next;
        end
    end

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        if (i < LEVELS_W) begin : g_in
            assign lane_level[i] = s_levels[i];
        end else begin : g_pad
            assign lane_level[i] = 1'b0;
        end

        bplq_lane u_lane (
            .aclk             (aclk),
            .aresetn          (aresetn),
            .scan_accept      (scan_accept),
            .level            (lane_level[i]),
            .time_ms          (s_time_ms),
            .rearm_time_ms    (rearm_time_reg),
            .long_press_scans (long_scans_reg),
            .ev               (lane_ev[i])
        );
    end

    bplq_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .scan_accept (scan_accept),
        .in_ready    (s_tready),
        .lane_ev     (lane_ev),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

### test/tb_button_press_long_press_qualifier.sv
// Testbench for the button press and long-press qualifier: directed table, random scans, scoreboard.
`timescale 1ns / 1ps
module tb_button_press_long_press_qualifier;
    import bplq_pkg::*;

    localparam int  CLK_PERIOD     = 4;
    localparam int  RESET_CYCLES   = 10;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  MAX_REPORTS    = 10;
    localparam int  PHASES         = 4;
    localparam int  SCANS_PER_PHASE = 55;
    localparam int  DRAIN_CYCLES   = 20;
    localparam int  PLAN_LEN       = 25;
    localparam logic ROW_SCAN      = 1'b0;
    localparam logic ROW_CFG       = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  btn;
        logic              ind;
        logic              last;
    } beat_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [CFG_W-1:0]     reg_val;
        logic [LEVELS_W-1:0]  lv;
        logic [TIME_W-1:0]    stamp;
        logic                 lit;
        logic [KIND_W-1:0]    kind;
        logic [IDX_W-1:0]     btn;
        logic                 ind;
    } row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // scan state of the predictor
    logic                 btn_armed   [NUM_BUTTONS];
    logic [TIME_W-1:0]    press_stamp [NUM_BUTTONS];
    logic [COUNT_W-1:0]   low_scans   [NUM_BUTTONS];
    logic                 long_held   [NUM_BUTTONS];
    logic                 ind_level;
    logic [CFG_W-1:0]     rearm_ms;
    logic [CFG_W-1:0]     long_scans;

    beat_t beats_due[$];
    int    mismatches = 0;
    int    quiet      = 0;
    int    calm       = 0;

    // kind, register, value, levels, time_ms, literal, event, button, indicator
    row_t plan [PLAN_LEN] = '{
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'd0,        1'b1, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h00, 32'd0,        1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'd200,      1'b1, EV_NONE,  3'd0, 1'b1},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'd201,      1'b1, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3E, 32'hFFFFFFFF, 1'b1, EV_PRESS, 3'd0, 1'b1},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'd200,      1'b1, EV_NONE,  3'd0, 1'b0},
        '{ROW_CFG,  REG_LONG_SCANS, 16'd0, 6'h00, 32'd0,        1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h00, 32'd1000,     1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h00, 32'd1001,     1'b1, EV_NONE,  3'd0, 1'b1},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'd1002,     1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_CFG,  REG_REARM_TIME, 16'd0, 6'h00, 32'd0,        1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'd1000,     1'b1, EV_NONE,  3'd0, 1'b1},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'd1001,     1'b1, EV_NONE,  3'd0, 1'b0},
        '{ROW_CFG,  REG_REARM_TIME, 16'hFFFF, 6'h00, 32'd0,     1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_CFG,  REG_LONG_SCANS, 16'hFFFF, 6'h00, 32'd0,     1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h20, 32'd5,        1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h1F, 32'd6,        1'b1, EV_PRESS, 3'd5, 1'b1},
        '{ROW_CFG,  REG_LONG_SCANS, 16'd2, 6'h00, 32'd0,        1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3E, 32'd7,        1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3E, 32'd8,        1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3E, 32'd9,        1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'd10,       1'b0, EV_NONE,  3'd0, 1'b0},
        '{ROW_SCAN, REG_REARM_TIME, 16'd0, 6'h3F, 32'h80000000, 1'b1, EV_NONE,  3'd0, 1'b0},
        '{ROW_CFG,  REG_REARM_TIME, REARM_TIME_RST, 6'h00, 32'd0, 1'b0, EV_NONE, 3'd0, 1'b0},
        '{ROW_CFG,  REG_LONG_SCANS, LONG_SCANS_RST, 6'h00, 32'd0, 1'b0, EV_NONE, 3'd0, 1'b0}
    };

    button_press_long_press_qualifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic qualify_scan(input logic [LEVELS_W-1:0] lv, input logic [TIME_W-1:0] now,
                                input bit keep);
        beat_t             scan_beats[$];
        logic [TIME_W-1:0] elapsed;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            elapsed = now - press_stamp[b];
            if (!btn_armed[b] && lv[b] && elapsed > TIME_W'(rearm_ms)) begin
                btn_armed[b] = 1'b1;
                ind_level    = 1'b0;
            end
        end
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (btn_armed[b] && !lv[b]) begin
                scan_beats.push_back('{EV_PRESS, IDX_W'(b), 1'b0, 1'b0});
                btn_armed[b]   = 1'b0;
                press_stamp[b] = now;
                ind_level      = 1'b1;
            end
            if (!lv[b]) begin
                if (!long_held[b]) begin
                    low_scans[b] = low_scans[b] + 1'b1;
                    if (low_scans[b] > COUNT_W'(long_scans)) begin
                        scan_beats.push_back('{EV_LONG, IDX_W'(b), 1'b0, 1'b0});
                        long_held[b] = 1'b1;
                        low_scans[b] = '0;
                    end
                end
            end else begin
                low_scans[b] = '0;
                if (long_held[b]) begin
                    long_held[b] = 1'b0;
                    scan_beats.push_back('{EV_LONG_REL, IDX_W'(b), 1'b0, 1'b0});
                end
            end
        end
        if (scan_beats.size() == 0) begin
            scan_beats.push_back('{EV_NONE, IDX_W'(0), 1'b0, 1'b0});
        end
        foreach (scan_beats[k]) begin
            scan_beats[k].ind  = ind_level;
            scan_beats[k].last = (k == scan_beats.size() - 1);
            if (keep) begin
                beats_due.push_back(scan_beats[k]);
            end
        end
    endtask

    task automatic send_scan(input row_t r);
        int gap;
        gap = (calm > 0) ? 0 : pick_gap();
        if (calm > 0) begin
            calm--;
        end else if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'({r.stamp, r.lv});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        qualify_scan(r.lv, r.stamp, !r.lit);
        if (r.lit) begin
            beats_due.push_back('{r.kind, r.btn, r.ind, 1'b1});
        end
    endtask

    // drop valid and hold until every due beat has arrived
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (beats_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
        cfg_index <= sel;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (sel)
            REG_REARM_TIME: rearm_ms   = val;
            REG_LONG_SCANS: long_scans = val;
            default: ;
        endcase
    endtask

    task automatic report(input string what, input beat_t want, input beat_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t %s: expected kind %0d button %0d ind %0d last %0d, got kind %0d button %0d ind %0d last %0d",
                     $time, what, want.kind, want.btn, want.ind, want.last,
                     got.kind, got.btn, got.ind, got.last);
        end
    endtask

    initial begin : sink
        int hold;
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = $urandom_range(1, 30);
            m_tready <= 1'b1;
            repeat (hold) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[IDX_W-1:0], m_tdata[IDX_W], m_tlast};
            if (beats_due.size() == 0) begin
                report("unexpected beat", '0, got);
            end else begin
                want = beats_due.pop_front();
                if (got.kind !== want.kind || got.btn !== want.btn ||
                    got.ind !== want.ind || got.last !== want.last) begin
                    report("beat mismatch", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("button_press_long_press_qualifier verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        row_t                r;
        logic [LEVELS_W-1:0] held;
        logic [TIME_W-1:0]   stamp;
        logic [CFG_W-1:0]    rv;
        logic [CFG_W-1:0]    ls;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_armed[b]   = 1'b1;
            press_stamp[b] = '0;
            low_scans[b]   = '0;
            long_held[b]   = 1'b0;
        end
        ind_level  = 1'b0;
        rearm_ms   = REARM_TIME_RST;
        long_scans = LONG_SCANS_RST;
        held       = '1;
        stamp      = $urandom;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[p]) begin
            if (plan[p].is_cfg == ROW_CFG) begin
                if (p == 0 || plan[p - 1].is_cfg != ROW_CFG) begin
                    settle();
                end
                write_reg(plan[p].reg_sel, plan[p].reg_val);
                if (p == PLAN_LEN - 1 || plan[p + 1].is_cfg != ROW_CFG) begin
                    cfg_valid <= 1'b0;
                end
            end else begin
                send_scan(plan[p]);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    rv = CFG_W'($urandom_range(0, 20));
                    ls = CFG_W'($urandom_range(0, 4));
                end
                1: begin
                    rv = '1;
                    ls = '0;
                end
                2: begin
                    rv = CFG_W'($urandom_range(0, 65535));
                    ls = CFG_W'($urandom_range(1, 6));
                end
                default: begin
                    rv = '0;
                    ls = CFG_W'($urandom_range(0, 3));
                end
            endcase
            write_reg(REG_REARM_TIME, rv);
            write_reg(REG_LONG_SCANS, ls);
            cfg_valid <= 1'b0;
            for (int n = 0; n < SCANS_PER_PHASE; n++) begin
                if ($urandom_range(0, 59) == 0) begin
                    settle();
                end
                r        = '0;
                r.is_cfg = ROW_SCAN;
                if ($urandom_range(0, 9) == 0) begin
                    r.lv = LEVELS_W'($urandom_range(0, 63));
                end else begin
                    for (int b = 0; b < NUM_BUTTONS; b++) begin
                        if (held[b] ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 5) == 0)) begin
                            held[b] = ~held[b];
                        end
                    end
                    r.lv = held;
                end
                case ($urandom_range(0, 9))
                    0: stamp = $urandom;
                    1, 2, 3: stamp = stamp + TIME_W'(rearm_ms) + TIME_W'($urandom_range(0, 2)) - 1;
                    default: stamp = stamp + TIME_W'($urandom_range(0, 3));
                endcase
                r.stamp = stamp;
                send_scan(r);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("button_press_long_press_qualifier verification clean");
        end else begin
            $display("button_press_long_press_qualifier verification failed");
        end
        $finish;
    end

endmodule
